### src/cst_pkg.sv
package cst_pkg;

  localparam int SLOT_COUNT  = 64;
  localparam int MAX_RESULTS = 64;
  localparam int IDX_W       = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int NCNT_W      = $clog2(MAX_RESULTS + 1);
  localparam logic [15:0] TIMEOUT_RESET = 16'd5000;

  typedef enum logic [1:0] {
    FN_SEND  = 2'd0,
    FN_RECV  = 2'd1,
    FN_CLOSE = 2'd2,
    FN_REAP  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_HIT     = 3'd0,
    ST_OPEN    = 3'd1,
    ST_RECYCLE = 3'd2,
    ST_TOUCH   = 3'd3,
    ST_STALE   = 3'd4,
    ST_CLOSED  = 3'd5,
    ST_REAPED  = 3'd6,
    ST_NONE    = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_EVENT,
    S_REAP,
    S_FIN
  } state_t;

  typedef struct packed {
    logic        active;
    logic [31:0] ip;
    logic [15:0] port;
    logic [31:0] last_used;
    logic        seq;
    logic [7:0]  gen;
  } entry_t;

endpackage

### src/cst_cell.sv
module cst_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  cst_pkg::entry_t d,
  output cst_pkg::entry_t q
);

  // key and timestamp have no reset; only the flags and generation are cleared
  always_ff @(posedge clk) begin
    if (en) begin
      q <= d;
    end
    if (rst) begin
      q.active <= 1'b0;
      q.seq    <= 1'b0;
      q.gen    <= '0;
    end
  end

endmodule

### src/connection_slot_table_lru.sv
// Send: one pass of the slot ring to search, then a second pass to write back.
// Receive, close and reap: one pass (none for an out-of-range event); a reap waits on the
// result side while it holds more than one closed slot. One item is in work at a time.
// The slot ring moves one entry per cycle past the head cell, except while a reap waits.
// Reset empties every slot, clears generations and sets the idle timeout to 5000 ms.
module connection_slot_table_lru (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  func,
  input  logic [31:0] dest_ip,
  input  logic [15:0] dest_port,
  input  logic        netchan_packet,
  input  logic [31:0] now_ms,
  input  logic [5:0]  event_slot,
  input  logic [7:0]  event_generation,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [5:0]  slot,
  output logic [7:0]  generation,
  output logic [2:0]  status,
  output logic [31:0] evicted_ip,
  output logic [15:0] evicted_port,
  output logic        last
);

  localparam int N = cst_pkg::SLOT_COUNT;
  localparam int W = cst_pkg::IDX_W;
  localparam logic [W-1:0] LAST_IDX = W'(N - 1);

  cst_pkg::state_t state, state_next;
  cst_pkg::entry_t q [N];
  cst_pkg::entry_t head, head_mod;
  logic            shift;

  logic [15:0] timeout;
  logic [1:0]  func_r;
  logic [31:0] ip_r, now_r;
  logic [15:0] port_r;
  logic        nc_r;
  logic [W-1:0] ev_idx;
  logic [7:0]  ev_gen;
  logic [W-1:0] cnt;

  logic         hit_v, free_v, bu_v, ba_v;
  logic [W-1:0] hit_idx, free_idx, bu_idx, ba_idx, tgt;
  logic [31:0]  bu_age, ba_age, age;

  logic [5:0]  res_slot;
  logic [7:0]  res_gen;
  logic [2:0]  res_status;
  logic [31:0] res_eip;
  logic [15:0] res_eport;

  logic         pend_v;
  logic [W-1:0] pend_idx;
  logic [7:0]   pend_gen;
  logic [cst_pkg::NCNT_W-1:0] n_reaped;

  logic accept, out_free, pass_end, match, reap_hit, reap_hold, ev_oor;

  // ring: each cell takes its neighbor, the tail takes the (possibly updated) head
  for (genvar i = 0; i < N; i++) begin : g_ring
    cst_pkg::entry_t d;
    if (i == N - 1) begin : g_tail
      assign d = head_mod;
    end else begin : g_mid
      assign d = q[i+1];
    end
    cst_cell u_cell (.clk(clk), .rst(rst), .en(shift), .d(d), .q(q[i]));
  end

  assign head      = q[0];
  assign age       = now_r - head.last_used;
  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != cst_pkg::S_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;
  assign pass_end  = (cnt == LAST_IDX);
  assign ev_oor    = (9'(event_slot) >= 9'(N));
  assign tgt       = hit_v ? hit_idx : (free_v ? free_idx : (bu_v ? bu_idx : ba_idx));
  assign match     = (state == cst_pkg::S_WRITE) ? (cnt == tgt) : (cnt == ev_idx);
  assign reap_hit  = head.active && !head.seq && !age[31] && (age >= {16'd0, timeout})
                     && (n_reaped < cst_pkg::NCNT_W'(cst_pkg::MAX_RESULTS));
  assign reap_hold = reap_hit && pend_v && !out_free;

  always_ff @(posedge clk) begin
    if (rst) state <= cst_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    shift      = 1'b0;
    head_mod   = head;
    unique case (state)
      cst_pkg::S_IDLE: begin
        if (accept) begin
          unique case (cst_pkg::func_t'(func))
            cst_pkg::FN_SEND:  state_next = cst_pkg::S_SCAN;
            cst_pkg::FN_RECV,
            cst_pkg::FN_CLOSE: state_next = ev_oor ? cst_pkg::S_FIN : cst_pkg::S_EVENT;
            cst_pkg::FN_REAP:  state_next = cst_pkg::S_REAP;
            default:           state_next = cst_pkg::S_IDLE;
          endcase
        end
      end
      cst_pkg::S_SCAN: begin
        shift = 1'b1;
        if (pass_end) state_next = cst_pkg::S_WRITE;
      end
      cst_pkg::S_WRITE: begin
        shift = 1'b1;
        if (match) begin
          head_mod.active    = 1'b1;
          head_mod.ip        = ip_r;
          head_mod.port      = port_r;
          head_mod.last_used = now_r;
          if (hit_v) begin
            head_mod.seq = head.seq | nc_r;
          end else begin
            head_mod.seq = nc_r;
            head_mod.gen = head.gen + 8'd1;
          end
        end
        if (pass_end) state_next = cst_pkg::S_FIN;
      end
      cst_pkg::S_EVENT: begin
        shift = 1'b1;
        if (match && head.active && head.gen == ev_gen) begin
          if (func_r == cst_pkg::FN_CLOSE) head_mod.active = 1'b0;
          else                             head_mod.last_used = now_r;
        end
        if (pass_end) state_next = cst_pkg::S_FIN;
      end
      cst_pkg::S_REAP: begin
        if (!reap_hold) begin
          shift = 1'b1;
          if (reap_hit) head_mod.active = 1'b0;
          if (pass_end) state_next = cst_pkg::S_FIN;
        end
      end
      cst_pkg::S_FIN: begin
        if (out_free) state_next = cst_pkg::S_IDLE;
      end
      default: state_next = cst_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) timeout <= cst_pkg::TIMEOUT_RESET;
    else if (cfg_we) timeout <= cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (shift) cnt <= pass_end ? '0 : cnt + W'(1);
      if (state == cst_pkg::S_REAP && shift && reap_hit && pend_v) begin
        rsp_valid <= 1'b1;
      end else if (state == cst_pkg::S_FIN && out_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r   <= func;
      ip_r     <= dest_ip;
      port_r   <= dest_port;
      nc_r     <= netchan_packet;
      now_r    <= now_ms;
      ev_idx   <= W'(event_slot);
      ev_gen   <= event_generation;
      hit_v    <= 1'b0;
      free_v   <= 1'b0;
      bu_v     <= 1'b0;
      ba_v     <= 1'b0;
      pend_v   <= 1'b0;
      n_reaped <= '0;
      // out-of-range event: answer straight away
      res_slot   <= event_slot;
      res_gen    <= '0;
      res_status <= cst_pkg::ST_STALE;
      res_eip    <= '0;
      res_eport  <= '0;
    end
    unique case (state)
      cst_pkg::S_SCAN: begin
        if (!hit_v && head.active && head.ip == ip_r && head.port == port_r) begin
          hit_v   <= 1'b1;
          hit_idx <= cnt;
        end
        if (!free_v && !head.active) begin
          free_v   <= 1'b1;
          free_idx <= cnt;
        end
        if (!head.seq && (!bu_v || age > bu_age)) begin
          bu_v   <= 1'b1;
          bu_idx <= cnt;
          bu_age <= age;
        end
        if (!ba_v || age > ba_age) begin
          ba_v   <= 1'b1;
          ba_idx <= cnt;
          ba_age <= age;
        end
      end
      cst_pkg::S_WRITE: begin
        if (match) begin
          res_slot  <= 6'(cnt);
          res_gen   <= head_mod.gen;
          res_eip   <= '0;
          res_eport <= '0;
          if (hit_v) begin
            res_status <= cst_pkg::ST_HIT;
          end else if (free_v) begin
            res_status <= cst_pkg::ST_OPEN;
          end else begin
            res_status <= cst_pkg::ST_RECYCLE;
            res_eip    <= head.ip;
            res_eport  <= head.port;
          end
        end
      end
      cst_pkg::S_EVENT: begin
        if (match) begin
          res_slot  <= 6'(cnt);
          res_gen   <= head.gen;
          res_eip   <= '0;
          res_eport <= '0;
          if (!head.active || head.gen != ev_gen)  res_status <= cst_pkg::ST_STALE;
          else if (func_r == cst_pkg::FN_CLOSE)    res_status <= cst_pkg::ST_CLOSED;
          else                                     res_status <= cst_pkg::ST_TOUCH;
        end
      end
      cst_pkg::S_REAP: begin
        if (shift && reap_hit) begin
          pend_v   <= 1'b1;
          pend_idx <= cnt;
          pend_gen <= head.gen;
          n_reaped <= n_reaped + cst_pkg::NCNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // result word register
  always_ff @(posedge clk) begin
    if (state == cst_pkg::S_REAP && shift && reap_hit && pend_v) begin
      slot         <= 6'(pend_idx);
      generation   <= pend_gen;
      status       <= cst_pkg::ST_REAPED;
      evicted_ip   <= '0;
      evicted_port <= '0;
      last         <= 1'b0;
    end else if (state == cst_pkg::S_FIN && out_free) begin
      last <= 1'b1;
      if (func_r == cst_pkg::FN_REAP) begin
        evicted_ip   <= '0;
        evicted_port <= '0;
        if (pend_v) begin
          slot       <= 6'(pend_idx);
          generation <= pend_gen;
          status     <= cst_pkg::ST_REAPED;
        end else begin
          slot       <= '0;
          generation <= '0;
          status     <= cst_pkg::ST_NONE;
        end
      end else begin
        slot         <= res_slot;
        generation   <= res_gen;
        status       <= res_status;
        evicted_ip   <= res_eip;
        evicted_port <= res_eport;
      end
    end
  end

endmodule

### src/cst_checker.sv
module cst_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_stall,
  input logic        rsp_valid,
  input logic        rsp_stall,
  input logic [5:0]  slot,
  input logic [2:0]  status,
  input logic [31:0] evicted_ip,
  input logic [15:0] evicted_port,
  input logic        last
);

  // one item in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while busy");

  a_hold_word: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(slot) && $stable(last))
    else $error("stalled result word changed");

  a_evict_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != cst_pkg::ST_RECYCLE |-> evicted_ip == '0 && evicted_port == '0)
    else $error("evicted key outside recycle");

  a_last_single: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != cst_pkg::ST_REAPED |-> last)
    else $error("single result without last");

  a_none_reaped: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == cst_pkg::ST_NONE |-> slot == '0)
    else $error("none reaped with nonzero slot");

endmodule

bind connection_slot_table_lru cst_checker u_cst_checker (
  .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall),
  .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .slot(slot), .status(status),
  .evicted_ip(evicted_ip), .evicted_port(evicted_port), .last(last)
);
